// ===== rtl/bmp_header_check_and_strip_defines.svh =====
// Assertion macros used by the port-level checker of the BMP header checker.
// Depends on nothing; the using scope must provide i_clk and i_rst_n.
`ifndef BMP_HEADER_CHECK_AND_STRIP_DEFINES_SVH
`define BMP_HEADER_CHECK_AND_STRIP_DEFINES_SVH

// Clocked, reset-gated implication check
`define BHCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Same check, but also evaluated while reset is held
`define BHCS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/bhcs_pkg.sv =====
// Shared types and constants for the BMP header checker.
// No dependencies; imported by every RTL module of the block.
package bhcs_pkg;

    localparam logic [15:0] SIGNATURE       = 16'h4D42;
    localparam logic [31:0] MIN_DATA_OFFSET = 32'd54;
    localparam logic [15:0] BITS_PER_POINT  = 16'd24;
    localparam logic [15:0] PLANES_VALUE    = 16'd1;

    // Positions of the final byte of each checked header field
    localparam logic [31:0] POS_SIGNATURE   = 32'd1;
    localparam logic [31:0] POS_FILE_SIZE   = 32'd5;
    localparam logic [31:0] POS_DATA_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH       = 32'd21;
    localparam logic [31:0] POS_HEIGHT      = 32'd25;
    localparam logic [31:0] POS_PLANES      = 32'd27;
    localparam logic [31:0] POS_BPP         = 32'd29;
    localparam logic [31:0] POS_COMPRESSION = 32'd33;
    localparam logic [31:0] POS_IMAGE_SIZE  = 32'd37;
    localparam logic [31:0] POS_LAST_HEADER = 32'd53;
    localparam logic [31:0] POS_MAX         = 32'hFFFF_FFFF;

    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam int OUT_TDATA_W = 112;

    typedef struct packed {
        logic       last_byte;
        logic [7:0] byte_value;
    } t_item;

    typedef struct packed {
        logic        result_kind;
        logic        header_valid;
        logic [31:0] image_width;
        logic [31:0] image_height;
        logic [31:0] pixel_start;
        logic [7:0]  pixel_byte;
        logic        end_of_file;
    } t_result;

endpackage

// ===== rtl/bhcs_parser.sv =====
// Header field assembly, checks and pixel forwarding decision.
// Depends on bhcs_pkg; updates its state once per consumed item.
module bhcs_parser
    import bhcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    logic [31:0] r_pos, n_pos;
    logic [31:0] r_fa, n_fa;
    logic        r_ok, n_ok;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [31:0] r_start, n_start;
    logic        r_sent, n_sent;
    logic [15:0] half;

    always_comb begin
        n_fa     = r_fa;
        n_ok     = r_ok;
        n_width  = r_width;
        n_height = r_height;
        n_start  = r_start;
        n_sent   = r_sent;
        half     = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!r_sent) begin
            n_fa = {i_item.byte_value, r_fa[31:8]};
            half = n_fa[31:16];
            case (r_pos)
                POS_SIGNATURE:   if (half != SIGNATURE) n_ok = 1'b0;
                POS_FILE_SIZE:   if (n_fa == '0) n_ok = 1'b0;
                POS_DATA_OFFSET: begin
                    n_start = n_fa;
                    if (n_fa < MIN_DATA_OFFSET) n_ok = 1'b0;
                end
                POS_WIDTH: begin
                    n_width = n_fa;
                    if (n_fa == '0) n_ok = 1'b0;
                end
                POS_HEIGHT: begin
                    n_height = n_fa;
                    if (n_fa == '0) n_ok = 1'b0;
                end
                POS_PLANES:      if (half != PLANES_VALUE) n_ok = 1'b0;
                POS_BPP:         if (half != BITS_PER_POINT) n_ok = 1'b0;
                POS_COMPRESSION: if (n_fa != '0) n_ok = 1'b0;
                POS_IMAGE_SIZE:  if (n_fa == '0) n_ok = 1'b0;
                default: ;
            endcase
            if (r_pos == POS_LAST_HEADER || i_item.last_byte) begin
                o_res_valid        = 1'b1;
                o_res.result_kind  = KIND_VERDICT;
                o_res.header_valid = (r_pos == POS_LAST_HEADER) ? n_ok : 1'b0;
                o_res.image_width  = n_width;
                o_res.image_height = n_height;
                o_res.pixel_start  = n_start;
                o_res.end_of_file  = i_item.last_byte;
            end
            if (r_pos == POS_LAST_HEADER) n_sent = 1'b1;
        end else if (r_ok && r_pos >= r_start) begin
            o_res_valid        = 1'b1;
            o_res.result_kind  = KIND_PIXEL;
            o_res.header_valid = 1'b1;
            o_res.pixel_byte   = i_item.byte_value;
            o_res.end_of_file  = i_item.last_byte;
        end

        n_pos = (r_pos != POS_MAX) ? r_pos + 32'd1 : r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fa     <= '0;
            r_ok     <= 1'b1;
            r_width  <= '0;
            r_height <= '0;
            r_start  <= '0;
            r_sent   <= 1'b0;
        end else if (i_take) begin
            if (i_item.last_byte) begin
                // rearm for the next file
                r_pos    <= '0;
                r_fa     <= '0;
                r_ok     <= 1'b1;
                r_width  <= '0;
                r_height <= '0;
                r_start  <= '0;
                r_sent   <= 1'b0;
            end else begin
                r_pos    <= n_pos;
                r_fa     <= n_fa;
                r_ok     <= n_ok;
                r_width  <= n_width;
                r_height <= n_height;
                r_start  <= n_start;
                r_sent   <= n_sent;
            end
        end
    end

endmodule

// ===== rtl/bhcs_out_stage.sv =====
// Result register driving the master-side item stream.
// Depends on bhcs_pkg for the result record and tdata width.
module bhcs_out_stage
    import bhcs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  t_result                i_res,
    output logic                   o_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_res.pixel_byte, r_res.pixel_start,
                            r_res.image_height, r_res.image_width, r_res.header_valid};
    assign m_axis_tlast  = r_res.end_of_file;
    assign m_axis_tuser  = r_res.result_kind;

endmodule

// ===== rtl/bmp_header_check_and_strip.sv =====
// Top level of the BMP header checker: input register, parser, result register.
// Depends on bhcs_pkg, bhcs_parser and bhcs_out_stage.
//
//  channel   | direction | payload                                   | end mark
//  ----------+-----------+-------------------------------------------+---------------
//  s_axis    | in        | tdata: file byte                          | tlast: last byte
//  m_axis    | out       | tdata: verdict fields or pixel byte       | tlast: end of file
//                          tuser: 0 verdict, 1 pixel byte
//
//  One item per clock while the result register is not stalled: each byte is held
//  in the input register until the parser takes it, then the parser state and the
//  result register are updated together. A result is shown in the cycle after
//  the parser takes its item.
//  Reset (synchronous, active low) clears the parser state and both valid flags.
//  A stalled result holds; the input register takes items while it is empty or
//  while the result register is free or being drained in the same cycle.
module bmp_header_check_and_strip
    import bhcs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // slave side
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,  // [7:0] byte_value
    input  logic                   s_axis_tlast,  // last_byte
    // master side
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // [0] header_valid, [32:1] image_width,
                                                  // [64:33] image_height, [96:65] pixel_start,
                                                  // [104:97] pixel_byte, [111:105] zero
    output logic                   m_axis_tlast,  // end_of_file
    output logic                   m_axis_tuser   // [0] result_kind
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    out_free;
    logic    take;
    logic    res_valid;
    t_result res;

    // Consume the held item whenever the result register can take its outcome
    assign take          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    // Hold the payload; no reset needed
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= '{last_byte: s_axis_tlast, byte_value: s_axis_tdata};
        end
    end

    bhcs_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_item      (r_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Load only items that yield a result; others just advance the parser
    bhcs_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (take && res_valid),
        .i_res         (res),
        .o_free        (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== rtl/bhcs_checker.sv =====
// Port-level checks on the BMP header checker, bound to its top level.
// Depends on bhcs_pkg and bmp_header_check_and_strip_defines.svh.
`include "bmp_header_check_and_strip_defines.svh"

module bhcs_checker
    import bhcs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast,
    input logic                   m_axis_tuser
);

    logic                   out_stall;
    logic [OUT_TDATA_W+1:0] out_word;
    logic                   is_pixel;
    logic                   pixel_clean;
    logic                   verdict_clean;

    assign out_stall     = m_axis_tvalid && !m_axis_tready;
    assign out_word      = {m_axis_tuser, m_axis_tlast, m_axis_tdata};
    assign is_pixel      = m_axis_tvalid && (m_axis_tuser == KIND_PIXEL);
    assign pixel_clean   = m_axis_tdata[0] && (m_axis_tdata[96:1] == '0);
    assign verdict_clean = (m_axis_tdata[OUT_TDATA_W-1:105] == '0)
                           && (m_axis_tuser == KIND_PIXEL || m_axis_tdata[104:97] == '0);

    // a stalled result keeps its payload
    `BHCS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_word), "result changed")

    // pixel items carry only the byte and a set valid flag
    `BHCS_ASSERT(a_pixel_clean, is_pixel |-> pixel_clean, "pixel item carries verdict fields")

    // verdicts leave the pixel byte clear, padding always clear
    `BHCS_ASSERT(a_verdict_clean, m_axis_tvalid |-> verdict_clean, "stray bits in result")

    // an empty result register never refuses input
    `BHCS_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready, "input refused")

    // nothing is shown in the cycle after reset
    `BHCS_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind bmp_header_check_and_strip bhcs_checker u_bhcs_checker (.*);
